// ----- src/phl_pkg.sv -----
package phl_pkg;

	localparam int SLOTS   = 1024;
	localparam int BUCKETS = 1024;
	localparam int SLOT_AW = $clog2(SLOTS);
	localparam int BKT_AW  = $clog2(BUCKETS);
	localparam int CNT_W   = 11;

	localparam logic [63:0] SEED_ONE   = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [63:0] SEED_TWO   = 64'hBB67_AE85_84CA_A73B;
	// FNV prime is 2^40 + 0x1B3
	localparam int          FNV_SHIFT  = 40;
	localparam logic [8:0]  FNV_LOW    = 9'h1B3;
	localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

	localparam logic [1:0] MODE_HASH   = 2'd0;
	localparam logic [1:0] MODE_DIRECT = 2'd1;
	localparam logic [1:0] MODE_SORTED = 2'd2;

	localparam logic [1:0] REQ_LOOKUP     = 2'd0;
	localparam logic [1:0] REQ_LOAD_PILOT = 2'd1;
	localparam logic [1:0] REQ_LOAD_SLOT  = 2'd2;

	localparam logic [1:0] REG_LOOKUP_MODE  = 2'd0;
	localparam logic [1:0] REG_MIN_KEY      = 2'd1;
	localparam logic [1:0] REG_SLOT_COUNT   = 2'd2;
	localparam logic [1:0] REG_BUCKET_COUNT = 2'd3;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIRECT,
		ST_HASH,
		ST_MOD_B,
		ST_PILOT_RD,
		ST_MUL,
		ST_MOD_S,
		ST_SRCH,
		ST_SRCH_CMP,
		ST_SLOT_RD,
		ST_SLOT_CHK,
		ST_MISS
	} state_t;

endpackage

// ----- src/perfect_hash_pilot_lookup_core.sv -----
// The next word may start in the cycle in which done is high.
// Hash mode is set by two 64-step bit-serial remainders and 8 FNV steps on one multiplier.
// Reset (arst_n low) initialises control and config; a sweep then zeroes the pilot table
// and used flags with busy high. The receiver cannot stall: each result is shown for
// one cycle with done.
module perfect_hash_pilot_lookup_core import phl_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          req_type,
	input  logic signed [31:0]  lookup_key,
	input  logic [9:0]          entry_index,
	input  logic [7:0]          pilot_in,
	input  logic signed [31:0]  value_in,
	input  logic                used_in,
	output logic                done,
	output logic                hit,
	output logic signed [31:0]  value_out,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_addr,
	input  logic [31:0]         cfg_data
);

	state_t state_q, state_d;

	logic [1:0]  mode_q;
	logic [31:0] min_key_q;
	logic [10:0] slot_count_q;
	logic [10:0] bucket_count_q;

	logic [1:0]         req_q;
	logic [31:0]        key_q;
	logic [63:0]        h1_q, h2_q, div_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [10:0]        rem_q;
	logic [10:0]        lo_q, hi_q;
	logic [SLOT_AW-1:0] pos_q;
	logic [BKT_AW-1:0]  bkt_q;
	logic               done_q, hit_q;
	logic [31:0]        value_q;

	logic [10:0] n_eff, nb_eff, div_d;
	logic [63:0] mul_a, mul_p, hash_x, hash_next;
	logic [8:0]  mul_b;
	logic [11:0] rem_sh, rem_sub;
	logic [10:0] rem_next;
	logic [32:0] offset;
	logic [10:0] mid;
	logic        accept, is_hash, last_step;

	logic               p_we, s_we;
	logic [BKT_AW-1:0]  p_waddr, p_raddr;
	logic [7:0]         p_wdata, p_rdata;
	logic [SLOT_AW-1:0] s_waddr, s_raddr;
	logic [64:0]        s_wdata, s_rdata;

	phl_ram #(.WIDTH(8), .DEPTH(BUCKETS)) u_pilot (
		.clk, .we(p_we), .waddr(p_waddr), .wdata(p_wdata), .raddr(p_raddr), .rdata(p_rdata)
	);

	// slot row: {used, value, key}
	phl_ram #(.WIDTH(65), .DEPTH(SLOTS)) u_slot (
		.clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rdata)
	);

	assign n_eff  = (slot_count_q > 11'(SLOTS)) ? 11'(SLOTS) : slot_count_q;
	assign nb_eff = (bucket_count_q == '0) ? 11'd1 :
		(bucket_count_q > 11'(BUCKETS)) ? 11'(BUCKETS) : bucket_count_q;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign last_step = (cnt_q[5:0] == 6'd63);

	// shared multiplier: FNV step or h2 * (pilot + 1)
	assign is_hash   = (state_q == ST_HASH);
	assign hash_x    = (cnt_q[2] ? h2_q : h1_q)
		^ {56'd0, 8'(key_q >> {cnt_q[1:0], 3'b000})};
	assign mul_a     = is_hash ? hash_x : h2_q;
	assign mul_b     = is_hash ? FNV_LOW : ({1'b0, p_rdata} + 9'd1);
	assign mul_p     = mul_a * 64'(mul_b);
	assign hash_next = (hash_x << FNV_SHIFT) + mul_p;

	// shared remainder step, one dividend bit per cycle
	assign div_d    = (state_q == ST_MOD_B) ? nb_eff : n_eff;
	assign rem_sh   = {rem_q, div_q[63]};
	assign rem_sub  = rem_sh - {1'b0, div_d};
	assign rem_next = (rem_sh >= {1'b0, div_d}) ? rem_sub[10:0] : rem_sh[10:0];

	assign offset = {key_q[31], key_q} - {min_key_q[31], min_key_q};
	assign mid    = lo_q + ((hi_q - lo_q) >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			cnt_q          <= '0;
			done_q         <= 1'b0;
			mode_q         <= MODE_HASH;
			min_key_q      <= '0;
			slot_count_q   <= '0;
			bucket_count_q <= 11'd1;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_addr)
					REG_LOOKUP_MODE:  mode_q         <= cfg_data[1:0];
					REG_MIN_KEY:      min_key_q      <= cfg_data;
					REG_SLOT_COUNT:   slot_count_q   <= cfg_data[10:0];
					REG_BUCKET_COUNT: bucket_count_q <= cfg_data[10:0];
					default:          mode_q         <= mode_q;
				endcase
			end
			done_q <= (state_q == ST_MISS) || (state_q == ST_SLOT_CHK);
			case (state_q)
				ST_CLEAR, ST_MOD_B, ST_MOD_S: cnt_q <= cnt_q + 1'b1;
				// restart the count so the bucket remainder gets all 64 steps
				ST_HASH: cnt_q <= (cnt_q[2:0] == 3'd7) ? '0 : cnt_q + 1'b1;
				default: cnt_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				req_q <= req_type;
				key_q <= lookup_key;
				h1_q  <= SEED_ONE;
				h2_q  <= SEED_TWO;
				lo_q  <= '0;
				hi_q  <= n_eff;
			end
			ST_DIRECT: pos_q <= offset[SLOT_AW-1:0];
			ST_HASH: begin
				if (cnt_q[2]) begin
					h2_q <= hash_next;
				end else begin
					h1_q <= hash_next;
				end
				div_q <= h1_q;
				rem_q <= '0;
			end
			ST_MOD_B, ST_MOD_S: begin
				div_q <= {div_q[62:0], 1'b0};
				rem_q <= rem_next;
				bkt_q <= rem_next[BKT_AW-1:0];
				pos_q <= rem_next[SLOT_AW-1:0];
			end
			ST_MUL: begin
				div_q <= h1_q ^ mul_p;
				rem_q <= '0;
			end
			ST_SRCH: pos_q <= (lo_q < hi_q) ? mid[SLOT_AW-1:0] : lo_q[SLOT_AW-1:0];
			ST_SRCH_CMP: begin
				if ($signed(s_rdata[31:0]) < $signed(key_q)) begin
					lo_q <= {1'b0, pos_q} + 11'd1;
				end else begin
					hi_q <= {1'b0, pos_q};
				end
			end
			ST_SLOT_CHK: begin
				hit_q   <= s_rdata[64] && (s_rdata[31:0] == key_q);
				value_q <= (s_rdata[64] && (s_rdata[31:0] == key_q)) ?
					s_rdata[63:32] : MISS_VALUE;
			end
			ST_MISS: begin
				hit_q   <= 1'b0;
				value_q <= MISS_VALUE;
			end
			default: rem_q <= rem_q;
		endcase
	end

	always_comb begin
		state_d = state_q;
		p_we    = 1'b0;
		p_waddr = entry_index;
		p_wdata = pilot_in;
		p_raddr = bkt_q;
		s_we    = 1'b0;
		s_waddr = entry_index;
		s_wdata = {used_in, value_in, lookup_key};
		s_raddr = pos_q;
		case (state_q)
			ST_CLEAR: begin
				// zero pilots and used flags, one row per cycle
				p_we    = 1'b1;
				s_we    = 1'b1;
				p_waddr = cnt_q[BKT_AW-1:0];
				s_waddr = cnt_q[SLOT_AW-1:0];
				p_wdata = '0;
				s_wdata = '0;
				if (cnt_q[SLOT_AW-1:0] == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					p_we = (req_type == REQ_LOAD_PILOT);
					s_we = (req_type == REQ_LOAD_SLOT);
					if (req_type != REQ_LOOKUP || n_eff == '0) begin
						state_d = ST_MISS;
					end else begin
						case (mode_q)
							MODE_HASH:   state_d = ST_HASH;
							MODE_DIRECT: state_d = ST_DIRECT;
							MODE_SORTED: state_d = ST_SRCH;
							default:     state_d = ST_MISS;
						endcase
					end
				end
			end
			ST_DIRECT: begin
				if (offset[32:11] == '0 && offset[10:0] < n_eff) begin
					state_d = ST_SLOT_RD;
				end else begin
					state_d = ST_MISS;
				end
			end
			ST_HASH:     if (cnt_q[2:0] == 3'd7) state_d = ST_MOD_B;
			ST_MOD_B:    if (last_step) state_d = ST_PILOT_RD;
			ST_PILOT_RD: state_d = ST_MUL;
			ST_MUL:      state_d = ST_MOD_S;
			ST_MOD_S:    if (last_step) state_d = ST_SLOT_RD;
			ST_SRCH: begin
				if (lo_q < hi_q) begin
					s_raddr = mid[SLOT_AW-1:0];
					state_d = ST_SRCH_CMP;
				end else if (lo_q >= n_eff) begin
					state_d = ST_MISS;
				end else begin
					state_d = ST_SLOT_RD;
				end
			end
			ST_SRCH_CMP: state_d = ST_SRCH;
			ST_SLOT_RD:  state_d = ST_SLOT_CHK;
			ST_SLOT_CHK: state_d = ST_IDLE;
			ST_MISS:     state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	assign done      = done_q;
	assign hit       = hit_q;
	assign value_out = value_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted word did not raise busy");

	a_miss_value: assert property (@(posedge clk) disable iff (!arst_n)
		done && !hit |-> value_out == MISS_VALUE) else $error("miss without -1");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MOD_S |-> rem_q < n_eff) else $error("slot remainder out of range");

endmodule

// ----- src/phl_ram.sv -----
module phl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- tb/perfect_hash_pilot_lookup_core_tb.sv -----
`timescale 1ns / 1ps
module perfect_hash_pilot_lookup_core_tb;
	import phl_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam logic [63:0] FNV_PRIME = 64'd1099511628211;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] req_type;
	logic signed [31:0] lookup_key;
	logic [9:0] entry_index;
	logic [7:0] pilot_in;
	logic signed [31:0] value_in;
	logic used_in;
	logic done;
	logic hit;
	logic signed [31:0] value_out;
	logic cfg_we;
	logic [1:0] cfg_addr;
	logic [31:0] cfg_data;

	typedef struct packed {
		logic        found;
		logic [31:0] value;
	} answer_t;

	// predictor copy of the block state
	logic [1:0]  m_mode;
	logic [31:0] m_min_key;
	logic [10:0] m_slot_count;
	logic [10:0] m_bucket_count;
	logic [7:0]  m_pilots [BUCKETS];
	logic [31:0] m_keys [SLOTS];
	logic [31:0] m_values [SLOTS];
	logic        m_used [SLOTS];

	answer_t answer_queue [$];
	int errors;
	int words_sent;
	int words_checked;
	int hits_seen;
	int idle_cycles;
	int send_idle_pct;

	perfect_hash_pilot_lookup_core u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .lookup_key(lookup_key), .entry_index(entry_index),
		.pilot_in(pilot_in), .value_in(value_in), .used_in(used_in),
		.done(done), .hit(hit), .value_out(value_out),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [63:0] fnv_key(logic [31:0] key, logic [63:0] seed);
		logic [63:0] h;
		h = seed;
		for (int i = 0; i < 4; i++) begin
			h = h ^ {56'd0, key[i*8 +: 8]};
			h = h * FNV_PRIME;
		end
		return h;
	endfunction

	function automatic answer_t find_key(logic [31:0] key);
		answer_t r;
		int n;
		int nb;
		longint off;
		logic [63:0] h1;
		logic [63:0] h2;
		logic [63:0] p;
		int pos;
		int lo;
		int hi;
		int mid;
		r.found = 1'b0;
		r.value = MISS_VALUE;
		n = (m_slot_count > SLOTS) ? SLOTS : int'(m_slot_count);
		nb = (m_bucket_count == 0) ? 1 : (m_bucket_count > BUCKETS) ? BUCKETS
			: int'(m_bucket_count);
		if (n == 0)
			return r;
		pos = -1;
		case (m_mode)
			MODE_HASH: begin
				h1 = fnv_key(key, SEED_ONE);
				h2 = fnv_key(key, SEED_TWO);
				p = {56'd0, m_pilots[h1 % nb]} + 64'd1;
				pos = int'((h1 ^ (h2 * p)) % n);
			end
			MODE_DIRECT: begin
				off = longint'($signed(key)) - longint'($signed(m_min_key));
				if (off >= 0 && off < n)
					pos = int'(off);
			end
			MODE_SORTED: begin
				lo = 0;
				hi = n;
				while (lo < hi) begin
					mid = lo + ((hi - lo) >> 1);
					if ($signed(m_keys[mid]) < $signed(key))
						lo = mid + 1;
					else
						hi = mid;
				end
				if (lo < n)
					pos = lo;
			end
			default: pos = -1;
		endcase
		if (pos >= 0 && m_used[pos] && m_keys[pos] == key) begin
			r.found = 1'b1;
			r.value = m_values[pos];
		end
		return r;
	endfunction

	task automatic idle_gap();
		if ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// send one word, predict its answer once busy drops; start stays up for the next word
	task automatic send_word(logic [1:0] rt, logic [31:0] key, logic [9:0] idx,
		logic [7:0] pil, logic [31:0] val, logic used);
		answer_t a;
		idle_gap();
		start <= 1'b1;
		req_type <= rt;
		lookup_key <= key;
		entry_index <= idx;
		pilot_in <= pil;
		value_in <= val;
		used_in <= used;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		a.found = 1'b0;
		a.value = MISS_VALUE;
		case (rt)
			REQ_LOOKUP: a = find_key(key);
			REQ_LOAD_PILOT: m_pilots[idx] = pil;
			REQ_LOAD_SLOT: begin
				m_keys[idx] = key;
				m_values[idx] = val;
				m_used[idx] = used;
			end
			default: ;
		endcase
		answer_queue.insert(answer_queue.size(), a);
		words_sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (answer_queue.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] addr, logic [31:0] data);
		drain();
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (addr)
			REG_LOOKUP_MODE: m_mode = data[1:0];
			REG_MIN_KEY: m_min_key = data;
			REG_SLOT_COUNT: m_slot_count = data[10:0];
			default: m_bucket_count = data[10:0];
		endcase
	endtask

	task automatic lookup(logic [31:0] key);
		send_word(REQ_LOOKUP, key, 10'($urandom), 8'($urandom), $urandom, 1'($urandom));
	endtask

	// sorted mode needs every searched key written; fill slots 0..n-1 ascending
	task automatic load_sorted(int n, logic [31:0] base, int stride);
		logic [31:0] k;
		k = base;
		for (int i = 0; i < n; i++) begin
			send_word(REQ_LOAD_SLOT, k, 10'(i), 8'($urandom), $urandom,
				($urandom_range(9) != 0));
			k = k + 32'($urandom_range(1, stride));
		end
	endtask

	task automatic test_directed();
		// empty table, reset registers
		lookup(32'h0);
		lookup(32'h8000_0000);
		send_word(REQ_LOAD_PILOT, 32'h0, 10'd1023, 8'hFF, 32'h0, 1'b0);
		send_word(REQ_LOAD_PILOT, 32'h0, 10'd0, 8'h00, 32'h0, 1'b0);
		send_word(REQ_LOAD_SLOT, 32'h7FFF_FFFF, 10'd1023, 8'h0, 32'h8000_0000, 1'b1);
		send_word(REQ_LOAD_SLOT, 32'h8000_0000, 10'd0, 8'h0, 32'h7FFF_FFFF, 1'b1);
		send_word(2'd3, 32'hFFFF_FFFF, 10'd0, 8'hFF, 32'hFFFF_FFFF, 1'b1);
		write_reg(REG_SLOT_COUNT, 32'd1024);
		write_reg(REG_LOOKUP_MODE, {30'd0, MODE_DIRECT});
		write_reg(REG_MIN_KEY, 32'h8000_0000);
		lookup(32'h8000_0000);
		lookup(32'h8000_0400);
		lookup(32'h7FFF_FFFF);
		write_reg(REG_MIN_KEY, 32'h7FFF_FC01);
		lookup(32'h7FFF_FFFF);
		lookup(32'h8000_0000);
		write_reg(REG_LOOKUP_MODE, 32'd3);
		lookup(32'h7FFF_FFFF);
		write_reg(REG_SLOT_COUNT, 32'h7FF);
		write_reg(REG_LOOKUP_MODE, {30'd0, MODE_HASH});
		write_reg(REG_BUCKET_COUNT, 32'd0);
		lookup(32'h7FFF_FFFF);
		write_reg(REG_BUCKET_COUNT, 32'h7FF);
		lookup(32'h8000_0000);
		lookup(32'h1234_5678);
	endtask

	// hash mode: place keys at the slot the predictor says
	task automatic test_hash(int nwords);
		logic [31:0] key;
		answer_t dummy;
		logic [63:0] h1;
		logic [63:0] h2;
		int nb;
		int n;
		int pos;
		n = $urandom_range(1, 40);
		nb = $urandom_range(1, 16);
		if ($urandom_range(5) == 0) begin
			n = $urandom_range(1000, 1024);
			nb = $urandom_range(1000, 1024);
		end
		write_reg(REG_LOOKUP_MODE, {30'd0, MODE_HASH});
		write_reg(REG_SLOT_COUNT, 32'(n));
		write_reg(REG_BUCKET_COUNT, 32'(nb));
		for (int i = 0; i < nb && i < 20; i++)
			send_word(REQ_LOAD_PILOT, $urandom, 10'($urandom_range(nb - 1)), 8'($urandom),
				$urandom, 1'($urandom));
		for (int i = 0; i < nwords; i++) begin
			key = $urandom;
			if ($urandom_range(1)) begin
				h1 = fnv_key(key, SEED_ONE);
				h2 = fnv_key(key, SEED_TWO);
				pos = int'((h1 ^ (h2 * ({56'd0, m_pilots[h1 % nb]} + 64'd1))) % n);
				send_word(REQ_LOAD_SLOT, key, 10'(pos), 8'($urandom), $urandom,
					($urandom_range(7) != 0));
			end
			lookup(key);
		end
		dummy = find_key(32'h0);
	endtask

	task automatic test_direct(int nwords);
		logic [31:0] base;
		int n;
		n = ($urandom_range(4) == 0) ? 1024 : $urandom_range(1, 64);
		base = $urandom;
		write_reg(REG_LOOKUP_MODE, {30'd0, MODE_DIRECT});
		write_reg(REG_SLOT_COUNT, 32'(n));
		write_reg(REG_MIN_KEY, base);
		for (int i = 0; i < nwords; i++) begin
			case ($urandom_range(3))
				0: send_word(REQ_LOAD_SLOT, base + $urandom_range(n - 1),
					10'($urandom_range(n - 1)), 8'($urandom), $urandom, 1'($urandom));
				1: lookup($urandom);
				default: lookup(base + $urandom_range(n + 2) - 1);
			endcase
		end
	endtask

	task automatic test_sorted(int nwords);
		logic [31:0] base;
		int n;
		int j;
		n = $urandom_range(1, 24);
		base = $urandom_range(1) ? 32'h8000_0000 : 32'($urandom_range(9)) - 32'd5;
		write_reg(REG_LOOKUP_MODE, {30'd0, MODE_SORTED});
		write_reg(REG_SLOT_COUNT, 32'(n));
		load_sorted(n, base, 5);
		for (int i = 0; i < nwords; i++) begin
			j = $urandom_range(n - 1);
			case ($urandom_range(3))
				0: lookup($urandom);
				1: lookup(m_keys[j] + 32'd1);
				default: lookup(m_keys[j]);
			endcase
		end
	endtask

	task automatic test_random(int total);
		while (words_sent < total) begin
			case ($urandom_range(3))
				0: test_hash($urandom_range(4, 12));
				1: test_direct($urandom_range(10, 40));
				2: test_sorted($urandom_range(10, 40));
				default: send_word(2'($urandom), $urandom, 10'($urandom), 8'($urandom),
					$urandom, 1'($urandom));
			endcase
		end
	endtask

	// check each result word against the oldest prediction
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && done) begin
			if (answer_queue.size() == 0) begin
				$display("%0t: result word with none expected: hit %0b value %h",
					$time, hit, value_out);
				errors++;
			end else begin
				want = answer_queue.pop_front();
				words_checked++;
				if (want.found)
					hits_seen++;
				if (hit !== want.found) begin
					$display("%0t: hit expected %0b actual %0b", $time, want.found, hit);
					errors++;
				end
				if (value_out !== want.value) begin
					$display("%0t: value_out expected %h actual %h", $time, want.value,
						value_out);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		errors = 0;
		words_sent = 0;
		words_checked = 0;
		hits_seen = 0;
		idle_cycles = 0;
		send_idle_pct = 26;
		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_LOOKUP;
		lookup_key = '0;
		entry_index = '0;
		pilot_in = '0;
		value_in = '0;
		used_in = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = REG_LOOKUP_MODE;
		cfg_data = '0;
		m_mode = MODE_HASH;
		m_min_key = '0;
		m_slot_count = '0;
		m_bucket_count = 11'd1;
		for (int i = 0; i < SLOTS; i++) begin
			m_pilots[i] = '0;
			m_keys[i] = '0;
			m_values[i] = '0;
			m_used[i] = 1'b0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(550);
		send_idle_pct = 72;
		test_random(1050);
		send_idle_pct = 0;
		test_random(1530);
		drain();
		repeat (200) @(posedge clk);
		$display("Sent %0d words over hash, direct and sorted tables; %0d results checked",
			words_sent, words_checked);
		$display("%0d lookups hit, %0d mismatches", hits_seen, errors);
		if (errors == 0 && answer_queue.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
